@@ design/wtok_pkg.sv @@
// ----------------------------------------------------------------------------
// wtok_pkg
// Shared types, codes and character constants of the whitespace tokenizer.
// ----------------------------------------------------------------------------
package wtok_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 127;
    localparam int QUEUE_DEPTH       = 4;
    localparam int VALUE_W           = 31;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    // result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_EOI  = 2'd2;

    // token classes
    localparam logic [1:0] CLASS_NUMBER = 2'd0;
    localparam logic [1:0] CLASS_SYMBOL = 2'd1;
    localparam logic [1:0] CLASS_NAME   = 2'd2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0a;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         tok_char;
        logic [1:0]         token_class;
        logic [VALUE_W-1:0] number_value;
        logic               too_long;
        logic               last;
    } wtok_result_t;

    // one accepted byte gives at most two results
    typedef struct packed {
        wtok_result_t first;
        wtok_result_t second;
        logic         two;
    } wtok_entry_t;

    typedef struct packed {
        wtok_entry_t head;
        logic        empty;
    } wtok_qhead_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

endpackage

@@ design/whitespace_tokenizer.sv @@
// ----------------------------------------------------------------------------
// whitespace_tokenizer
// Byte-stream lexer splitting on whitespace, with quotes and escapes.
// ----------------------------------------------------------------------------
// One input byte is taken per clock while the result queue is not full. A byte
// yields zero, one or two output transactions; the output side sends one per
// clock while m_tready is high, so a byte that both adds a character and ends
// a token (or ends the last token and the input) needs a second output
// transaction, absorbed by the four-entry result queue between the lexer and
// the output register. Token characters stream out as they arrive; a
// token-finished transaction then carries the class, the saturated number
// value and the truncation flag. There is no reset sweep: the block is ready
// right after reset.
module whitespace_tokenizer #(
    parameter int MaxTokenLen = wtok_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch
    input  logic [0:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // tok_char, token_class, number_value, too_long
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);

    logic                   accept, push, pop, full;
    wtok_pkg::wtok_entry_t  entry;
    wtok_pkg::wtok_qhead_t  qhead;
    wtok_pkg::wtok_result_t res;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    wtok_front #(
        .MaxTokenLen(MaxTokenLen)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .action  (s_tuser[0]),
        .ch      (s_tdata),
        .push    (push),
        .entry   (entry)
    );

    wtok_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (entry),
        .pop        (pop),
        .full       (full),
        .qhead      (qhead)
    );

    wtok_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .qhead     (qhead),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_res   (res),
        .out_ready (m_tready)
    );

    assign m_tdata = {6'b0, res.too_long, res.number_value, res.token_class, res.tok_char};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

@@ design/wtok_front.sv @@
// ----------------------------------------------------------------------------
// wtok_front
// Lexer state: quoting, escapes, token length, class and number value.
// Turns each accepted byte into zero, one or two results for the queue.
// ----------------------------------------------------------------------------
module wtok_front #(
    parameter int MaxTokenLen = wtok_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic                 action,
    input  logic [7:0]           ch,
    output logic                 push,
    output wtok_pkg::wtok_entry_t entry
);

    localparam int LW = $clog2(MaxTokenLen + 1);
    localparam int VW = wtok_pkg::VALUE_W;

    logic          inq_reg, inq_next;
    logic          esc_reg, esc_next;
    logic [LW-1:0] len_reg, len_next;
    logic [1:0]    fc_reg, fc_next;
    logic [VW-1:0] val_reg, val_next;
    logic          dr_reg, dr_next;
    logic          ov_reg, ov_next;

    logic          do_acc, do_close, do_eoi, acc_ok, close_emit;
    logic [7:0]    acc_char;
    logic          c_dig;
    logic [LW-1:0] len_a;
    logic [1:0]    fc_a;
    logic [VW-1:0] val_base, val_a;
    logic [VW+3:0] val_prod;
    logic          dr_a, ov_a;
    wtok_pkg::wtok_result_t r_acc, r_close, r_eoi;

    always_comb begin
        do_acc   = 1'b0;
        do_close = 1'b0;
        do_eoi   = 1'b0;
        acc_char = ch;
        esc_next = esc_reg;
        inq_next = inq_reg;
        if (action) begin
            do_close = 1'b1;
            do_eoi   = 1'b1;
        end else if (esc_reg) begin
            esc_next = 1'b0;
            if (ch == wtok_pkg::CH_N) begin
                do_acc   = 1'b1;
                acc_char = wtok_pkg::CH_NL;
            end else if (ch == wtok_pkg::CH_T) begin
                do_acc   = 1'b1;
                acc_char = wtok_pkg::CH_TAB;
            end else if (ch == wtok_pkg::CH_BSLASH) begin
                do_acc   = 1'b1;
                acc_char = wtok_pkg::CH_BSLASH;
            end else if (ch == wtok_pkg::CH_NL) begin
                do_close = 1'b1;
                inq_next = 1'b0;
            end
        end else if (ch == wtok_pkg::CH_NL) begin
            do_acc   = inq_reg;
            do_close = 1'b1;
            inq_next = 1'b0;
        end else if ((ch == wtok_pkg::CH_SPACE || ch == wtok_pkg::CH_TAB) && !inq_reg) begin
            do_close = 1'b1;
        end else if (ch == wtok_pkg::CH_QUOTE) begin
            inq_next = !inq_reg;
        end else if (ch == wtok_pkg::CH_BSLASH) begin
            esc_next = 1'b1;
        end else begin
            do_acc = 1'b1;
        end
        if (action) begin
            inq_next = 1'b0;
            esc_next = 1'b0;
        end
    end

    // character acceptance
    always_comb begin
        c_dig    = wtok_pkg::is_digit(acc_char);
        acc_ok   = do_acc && (len_reg < LW'(MaxTokenLen));
        len_a    = len_reg;
        fc_a     = fc_reg;
        dr_a     = dr_reg;
        ov_a     = ov_reg | (do_acc & !acc_ok);
        val_base = (len_reg == '0) ? '0 : val_reg;
        val_prod = ({4'b0, val_base} << 3) + ({4'b0, val_base} << 1)
                 + {{VW{1'b0}}, 4'(acc_char - wtok_pkg::CH_0)};
        val_a    = val_reg;
        if (acc_ok) begin
            len_a = len_reg + 1'b1;
            if (len_reg == '0) begin
                fc_a = c_dig ? wtok_pkg::CLASS_NUMBER :
                       (wtok_pkg::is_letter(acc_char) ? wtok_pkg::CLASS_NAME :
                        wtok_pkg::CLASS_SYMBOL);
                dr_a = c_dig;
            end else begin
                dr_a = dr_reg & c_dig;
            end
            if (dr_a) begin
                val_a = (val_prod > {4'b0, wtok_pkg::VALUE_MAX}) ? wtok_pkg::VALUE_MAX
                                                                  : val_prod[VW-1:0];
            end else begin
                val_a = val_base;
            end
        end
        close_emit = do_close && (len_a != '0);
    end

    always_comb begin
        r_acc              = '0;
        r_acc.kind         = wtok_pkg::KIND_CHAR;
        r_acc.tok_char     = acc_char;
        r_close            = '0;
        r_close.kind       = wtok_pkg::KIND_END;
        r_close.token_class = fc_a;
        r_close.number_value = (fc_a == wtok_pkg::CLASS_NUMBER) ? val_a : '0;
        r_close.too_long   = ov_a;
        r_eoi              = '0;
        r_eoi.kind         = wtok_pkg::KIND_EOI;

        entry = '0;
        if (acc_ok) begin
            entry.first = r_acc;
            if (close_emit) begin
                entry.second = r_close;
                entry.two    = 1'b1;
            end
        end else if (close_emit) begin
            entry.first = r_close;
            if (do_eoi) begin
                entry.second = r_eoi;
                entry.two    = 1'b1;
            end
        end else begin
            entry.first = r_eoi;
        end
        if (entry.two) begin
            entry.second.last = 1'b1;
        end else begin
            entry.first.last = 1'b1;
        end
        push = accept && (acc_ok || close_emit || do_eoi);

        if (do_close) begin
            len_next = '0;
            fc_next  = '0;
            val_next = '0;
            dr_next  = 1'b0;
            ov_next  = 1'b0;
        end else begin
            len_next = len_a;
            fc_next  = fc_a;
            val_next = val_a;
            dr_next  = dr_a;
            ov_next  = ov_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inq_reg <= 1'b0;
            esc_reg <= 1'b0;
            len_reg <= '0;
            fc_reg  <= '0;
            val_reg <= '0;
            dr_reg  <= 1'b0;
            ov_reg  <= 1'b0;
        end else if (accept) begin
            inq_reg <= inq_next;
            esc_reg <= esc_next;
            len_reg <= len_next;
            fc_reg  <= fc_next;
            val_reg <= val_next;
            dr_reg  <= dr_next;
            ov_reg  <= ov_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(MaxTokenLen))
        else $error("token length beyond maximum");

    a_eoi_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && action) |=> (len_reg == '0 && !esc_reg && !inq_reg && !ov_reg))
        else $error("end of input did not clear lexer state");
`endif

endmodule

@@ design/wtok_queue.sv @@
// ----------------------------------------------------------------------------
// wtok_queue
// Short FIFO of result pairs between the lexer front and the output side.
// ----------------------------------------------------------------------------
module wtok_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  wtok_pkg::wtok_entry_t push_entry,
    input  logic                  pop,
    output logic                  full,
    output wtok_pkg::wtok_qhead_t qhead
);

    localparam int Depth = wtok_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(Depth);
    localparam int CW    = $clog2(Depth + 1);

    wtok_pkg::wtok_entry_t mem_reg [Depth];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    always_comb begin
        full        = (count_reg == CW'(Depth));
        qhead.empty = (count_reg == '0);
        qhead.head  = mem_reg[rd_ptr_reg];
        do_push     = push && !full;
        do_pop      = pop && !qhead.empty;
        wr_ptr_next = (wr_ptr_reg == PW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next  = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full result queue");
`endif

endmodule

@@ design/wtok_back.sv @@
// ----------------------------------------------------------------------------
// wtok_back
// Output side: unpacks queued result pairs into single transactions and
// holds the current one in the output register.
// ----------------------------------------------------------------------------
module wtok_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  wtok_pkg::wtok_qhead_t  qhead,
    output logic                   pop,
    output logic                   out_valid,
    output wtok_pkg::wtok_result_t out_res,
    input  logic                   out_ready
);

    logic                   valid_reg, valid_next;
    logic                   sel_reg, sel_next;
    wtok_pkg::wtok_result_t res_reg, res_next;
    logic                   load;

    always_comb begin
        load       = !valid_reg || out_ready;
        valid_next = valid_reg;
        sel_next   = sel_reg;
        res_next   = res_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = !qhead.empty;
            res_next   = sel_reg ? qhead.head.second : qhead.head.first;
            if (!qhead.empty) begin
                if (qhead.head.two && !sel_reg) begin
                    sel_next = 1'b1;
                end else begin
                    sel_next = 1'b0;
                    pop      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

`ifndef NO_ASSERTIONS
    // the second half of a pair stays at the queue head until it is loaded into the output register
    a_pair_held: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_reg |-> (!qhead.empty && qhead.head.two))
        else $error("second result of a pair lost");
`endif

endmodule

@@ sim/whitespace_tokenizer_tb.sv @@
// ----------------------------------------------------------------------------
// whitespace_tokenizer_tb
// Drives byte streams into the tokenizer and checks every output transaction
// against a cycle-free lexer kept in the bench: token characters, finished
// tokens with class, number value and truncation flag, and end-of-input marks.
// Directed bytes come first, then random token streams with random gaps and
// stalls on both sides.
// ----------------------------------------------------------------------------
module whitespace_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wtok_pkg::*;

    localparam int          TOK_MAX   = MAX_TOKEN_LEN_DEF;
    localparam int          ITEMS     = 1950;
    localparam int          WATCHDOG  = 5000;
    localparam int          LONG_HOLD = 150;
    localparam int unsigned VAL_TOP   = 32'h7fff_ffff;

    // input action codes
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_EOI  = 1'b1;

    typedef struct packed {
        logic       act;
        logic [7:0] ch;
        logic       hold;   // wait for all results before offering
    } feed_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    whitespace_tokenizer #(
        .MaxTokenLen (TOK_MAX)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    feed_t        byte_q[$];
    wtok_result_t token_out_q[$];

    // lexer state of the bench
    logic        quoting = 1'b0;
    logic        esc_pending = 1'b0;
    int          tok_len = 0;
    logic [1:0]  tok_class = CLASS_NUMBER;
    int unsigned tok_value = 0;
    logic        digits_live = 1'b0;
    logic        tok_trunc = 1'b0;

    int   errors = 0;
    int   n_in = 0;
    int   n_out = 0;
    int   n_tokens = 0;
    int   n_trunc = 0;
    int   n_sat = 0;
    int   n_eoi = 0;
    int   n_made = 0;
    int   n_long = 0;
    int   idle = 0;
    int   cyc = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    int   holds_done = 0;
    logic in_taken = 1'b0;
    logic pause_next = 1'b0;
    logic calm;

    // quiet stretches with no random gaps or stalls on either side
    assign calm = (cyc[9:8] == 2'b00);

    // ------------------------------------------------------------------
    // lexer model
    // ------------------------------------------------------------------
    function automatic void push_result(logic [1:0] kind, logic [7:0] c, logic [1:0] cls,
                                        logic [VALUE_W-1:0] val, logic trunc);
        wtok_result_t r;
        r.kind         = kind;
        r.tok_char     = c;
        r.token_class  = cls;
        r.number_value = val;
        r.too_long     = trunc;
        r.last         = 1'b0;
        token_out_q.push_back(r);
    endfunction

    function automatic void clear_token();
        tok_len     = 0;
        tok_class   = CLASS_NUMBER;
        tok_value   = 0;
        digits_live = 1'b0;
        tok_trunc   = 1'b0;
    endfunction

    function automatic void take_char(logic [7:0] c);
        logic        dig;
        int unsigned d;
        dig = (c >= CH_0) && (c <= CH_9);
        if (tok_len >= TOK_MAX) begin
            tok_trunc = 1'b1;
            return;
        end
        if (tok_len == 0) begin
            if (dig)
                tok_class = CLASS_NUMBER;
            else if ((c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ))
                tok_class = CLASS_NAME;
            else
                tok_class = CLASS_SYMBOL;
            digits_live = dig;
            tok_value   = 0;
        end else if (!dig) begin
            digits_live = 1'b0;
        end
        if (digits_live) begin
            d = 32'(c - CH_0);
            if (tok_value > (VAL_TOP - d) / 10)
                tok_value = VAL_TOP;
            else
                tok_value = tok_value * 10 + d;
        end
        tok_len++;
        push_result(KIND_CHAR, c, CLASS_NUMBER, '0, 1'b0);
    endfunction

    function automatic void close_token();
        if (tok_len > 0) begin
            push_result(KIND_END, 8'h00, tok_class,
                        (tok_class == CLASS_NUMBER) ? tok_value[VALUE_W-1:0] : '0, tok_trunc);
            n_tokens++;
            if (tok_trunc)
                n_trunc++;
            if (tok_class == CLASS_NUMBER && tok_value == VAL_TOP)
                n_sat++;
        end
        clear_token();
    endfunction

    function automatic void lex_byte(logic act, logic [7:0] c);
        int           base;
        wtok_result_t r;
        base = token_out_q.size();
        if (act == ACT_EOI) begin
            close_token();
            push_result(KIND_EOI, 8'h00, CLASS_NUMBER, '0, 1'b0);
            n_eoi++;
            quoting     = 1'b0;
            esc_pending = 1'b0;
        end else if (esc_pending) begin
            esc_pending = 1'b0;
            case (c)
                CH_N:      take_char(CH_NL);
                CH_T:      take_char(CH_TAB);
                CH_BSLASH: take_char(CH_BSLASH);
                CH_NL: begin
                    // escaped line end still ends the line
                    close_token();
                    quoting = 1'b0;
                end
                default: ;
            endcase
        end else if (c == CH_NL) begin
            if (quoting)
                take_char(CH_NL);
            close_token();
            quoting = 1'b0;
        end else if ((c == CH_SPACE || c == CH_TAB) && !quoting) begin
            close_token();
        end else if (c == CH_QUOTE) begin
            quoting = !quoting;
        end else if (c == CH_BSLASH) begin
            esc_pending = 1'b1;
        end else begin
            take_char(c);
        end
        if (token_out_q.size() > base) begin
            r = token_out_q[token_out_q.size() - 1];
            r.last = 1'b1;
            token_out_q[token_out_q.size() - 1] = r;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 0)
            return CH_UA + 8'($urandom_range(0, 25));
        return CH_LA + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    task automatic put_item(logic act, logic [7:0] c);
        feed_t f;
        f.act  = act;
        f.ch   = c;
        f.hold = pause_next;
        byte_q.push_back(f);
        pause_next = 1'b0;
        n_made++;
    endtask

    task automatic put_ch(logic [7:0] c);
        put_item(ACT_CHAR, c);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_ch(s[i]);
    endtask

    task automatic put_random_token();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) == 0)
            pause_next = 1'b1;
        if (pick < 38) begin
            put_ch(rand_letter());
            len = $urandom_range(0, 7);
            repeat (len) put_ch(($urandom_range(0, 1) == 0) ? rand_letter() : rand_digit());
        end else if (pick < 60) begin
            // mostly short numbers, some long enough to saturate
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 6);
            repeat (len) put_ch(rand_digit());
            if ($urandom_range(0, 4) == 0)
                put_ch(rand_letter());
        end else if (pick < 70) begin
            put_ch(CH_QUOTE);
            len = $urandom_range(0, 6);
            repeat (len) begin
                case ($urandom_range(0, 5))
                    0:       put_ch(CH_SPACE);
                    1:       put_ch(CH_TAB);
                    2:       put_ch(CH_NL);
                    default: put_ch(rand_letter());
                endcase
            end
            if ($urandom_range(0, 4) != 0)
                put_ch(CH_QUOTE);
        end else if (pick < 78) begin
            put_ch(rand_letter());
            repeat ($urandom_range(1, 3)) begin
                put_ch(CH_BSLASH);
                case ($urandom_range(0, 4))
                    0:       put_ch(CH_N);
                    1:       put_ch(CH_T);
                    2:       put_ch(CH_BSLASH);
                    3:       put_ch(CH_NL);
                    default: put_ch(8'($urandom_range(0, 255)));
                endcase
            end
        end else if (pick < 88) begin
            repeat ($urandom_range(1, 4)) put_ch(8'($urandom_range(0, 255)));
        end else if (pick < 93) begin
            // symbol-led token, from '#' up to '/'
            put_ch(8'($urandom_range(CH_QUOTE + 1, CH_0 - 1)));
            repeat ($urandom_range(0, 4)) put_ch(rand_digit());
        end else if (pick < 95 && n_long < 4) begin
            // runs near or past the length limit, some all digits
            n_long++;
            len = $urandom_range(TOK_MAX - 3, TOK_MAX + 12);
            if ($urandom_range(0, 1) == 0)
                repeat (len) put_ch(rand_digit());
            else
                repeat (len) put_ch(rand_letter());
        end else begin
            if ($urandom_range(0, 2) == 0)
                put_ch(CH_BSLASH);
            put_item(ACT_EOI, 8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: put_ch(CH_SPACE);
            5, 6:          put_ch(CH_TAB);
            7:             put_ch(CH_NL);
            8: begin
                put_ch(CH_SPACE);
                put_ch(CH_SPACE);
                put_ch(CH_TAB);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // driver: offers one byte transaction at a time from byte_q
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive
        feed_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (byte_q.size() > 0 && !(byte_q[0].hold && token_out_q.size() > 0)) begin
                nxt = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.ch;
                s_tuser  <= nxt.act;
                gap_left <= calm ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls plus two long hold-offs
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if ((holds_done == 0 && n_in >= 400) || (holds_done == 1 && n_in >= 1300)) begin
            hold_left  <= LONG_HOLD;
            holds_done <= holds_done + 1;
            m_tready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
            stall_left <= calm ? 0 : pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks results, then feeds accepted bytes to the lexer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch
        wtok_result_t got;
        wtok_result_t want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind         = m_tuser;
                got.tok_char     = m_tdata[7:0];
                got.token_class  = m_tdata[9:8];
                got.number_value = m_tdata[40:10];
                got.too_long     = m_tdata[41];
                got.last         = m_tlast;
                n_out++;
                if (token_out_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display({"%0t: unexpected result kind=%0d char=%02h class=%0d",
                                  " val=%0d long=%0b last=%0b"},
                                 $realtime, got.kind, got.tok_char, got.token_class,
                                 got.number_value, got.too_long, got.last);
                end else begin
                    want = token_out_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: result %0d: kind %0d/%0d char %02h/%02h",
                                      " class %0d/%0d val %0d/%0d long %0b/%0b",
                                      " last %0b/%0b (exp/got)"},
                                     $realtime, n_out, want.kind, got.kind, want.tok_char,
                                     got.tok_char, want.token_class, got.token_class,
                                     want.number_value, got.number_value, want.too_long,
                                     got.too_long, want.last, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                n_in++;
                lex_byte(s_tuser[0], s_tdata);
            end
            in_taken <= s_tvalid && s_tready;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle <= 0;
        end else if (idle >= WATCHDOG) begin
            $display("timeout after %0d idle cycles, %0d results outstanding",
                     idle, token_out_q.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle <= idle + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int n_directed;
        // number with a letter tail, then a quoted token closed by a line end
        put_text("9z ");
        put_text("\"a b\n");
        // escapes: newline, tab, backslash, and one that is dropped
        put_text("\\n\\t\\\\\\q ");
        // escaped line end closes the token
        put_text("x\\\n");
        // empty tokens, then a symbol token of bytes 00 and ff
        put_text("  ");
        put_ch(8'h00);
        put_ch(8'hff);
        put_ch(CH_TAB);
        // end of input with a pending token, then with a pending backslash
        put_ch(CH_9);
        put_item(ACT_EOI, 8'hff);
        put_ch(CH_BSLASH);
        put_item(ACT_EOI, 8'h00);
        n_directed = n_made;

        pause_next = 1'b1;
        while (n_made < n_directed + ITEMS)
            put_random_token();
        put_item(ACT_EOI, 8'h00);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        @(posedge aclk);
        while (byte_q.size() > 0 || s_tvalid)
            @(posedge aclk);
        while (token_out_q.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (token_out_q.size() > 0) begin
            $display("%0d results never arrived", token_out_q.size());
            errors += token_out_q.size();
        end
        $display("covered %0d bytes in, %0d results out: %0d tokens, %0d truncated, %0d saturated",
                 n_in, n_out, n_tokens, n_trunc, n_sat);
        $display("%0d end-of-input marks, %0d long receiver hold-offs, %0d mismatches",
                 n_eoi, holds_done, errors);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
